>>> src/sceacc_pkg.sv
package sceacc_pkg;

  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int RADIUS_W   = 11;
  localparam int OFFSET_W   = 8;
  localparam int MARGIN_W   = 10;
  localparam int CUT_W      = 12;
  localparam int RR_W       = 13;
  localparam int URR_W      = 12;
  localparam int BIGR_W     = URR_W + 8;
  localparam int DSQ_W      = 50;
  localparam int MUL_IN_W   = 29;
  localparam int PROD_W     = 56;
  localparam int ROOT_W     = 40;
  localparam int CNT_W      = 5;
  localparam int ENERGY_W   = 14;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int SQRT_STEPS = 20;
  localparam int DIV_STEPS  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MARGIN = 8'd1;

  localparam logic [OFFSET_W-1:0] RADIUS_OFFSET_RST = 8'd64;
  localparam logic [MARGIN_W-1:0] SEARCH_MARGIN_RST = 10'd435;

  // 0.8254 in Q16, 57.273 in 1/256 units, 10.0 in 1/256 units
  localparam logic [15:0]         CORE_Q16    = 16'd54093;
  localparam logic [ENERGY_W-1:0] RAMP_SCALE  = 14'd14662;
  localparam logic [ENERGY_W-1:0] CORE_ENERGY = 14'd2560;
  localparam logic [SUM_W-1:0]    SUM_MAX     = {SUM_W{1'b1}};

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } root_op_t;

  typedef struct packed {
    logic              start;
    root_op_t          op;
    logic [ROOT_W-1:0] num;
    logic [ROOT_W-1:0] den;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } root_sts_t;

endpackage

>>> src/sceacc_if.sv
interface sceacc_in_if;
  import sceacc_pkg::*;

  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  a_x;
  logic [COORD_W-1:0]  a_y;
  logic [COORD_W-1:0]  a_z;
  logic [RADIUS_W-1:0] a_radius;
  logic [COORD_W-1:0]  b_x;
  logic [COORD_W-1:0]  b_y;
  logic [COORD_W-1:0]  b_z;
  logic [RADIUS_W-1:0] b_radius;
  logic                last_pair;

  modport source (
    output valid, a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, last_pair,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, last_pair,
    output ready
  );
endinterface

interface sceacc_out_if;
  import sceacc_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] total_energy;
  logic             saturated;

  modport source (output valid, total_energy, saturated, input ready);
  modport sink (input valid, total_energy, saturated, output ready);
endinterface

interface sceacc_cfg_if;
  import sceacc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/sceacc_mul.sv
module sceacc_mul (
  input  logic                                   clk,
  input  logic signed [sceacc_pkg::MUL_IN_W-1:0] op_a,
  input  logic signed [sceacc_pkg::MUL_IN_W-1:0] op_b,
  output logic        [sceacc_pkg::PROD_W-1:0]   prod_r
);
  import sceacc_pkg::*;

  logic signed [2*MUL_IN_W-1:0] prod_full;

  assign prod_full = op_a * op_b;

  // every product the sequencer asks for is nonnegative and fits PROD_W
  always_ff @(posedge clk) begin
    prod_r <= prod_full[PROD_W-1:0];
  end

endmodule

>>> src/sceacc_root.sv
module sceacc_root (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sceacc_pkg::root_req_t req,
  output sceacc_pkg::root_sts_t sts
);
  import sceacc_pkg::*;

  localparam logic [ROOT_W-1:0] SQRT_BIT0 = ROOT_W'(1) << (ROOT_W - 2);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  root_op_t          op_r;
  logic [ROOT_W-1:0] rem_r;
  logic [ROOT_W-1:0] sub_r;
  logic [ROOT_W-1:0] q_r;

  logic [ROOT_W-1:0] trial;
  logic [ROOT_W-1:0] diff;
  logic              fits;

  // one shared compare-subtract serves both the root and the quotient digits
  assign trial = (op_r == OP_SQRT) ? q_r + sub_r : sub_r;
  assign fits  = rem_r >= trial;
  assign diff  = rem_r - trial;

  assign sts.done   = done_r;
  assign sts.result = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == OP_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      rem_r <= req.num;
      q_r   <= '0;
      sub_r <= (req.op == OP_SQRT) ? SQRT_BIT0 : req.den;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= diff;
      end
      if (op_r == OP_SQRT) begin
        q_r   <= fits ? (q_r >> 1) + sub_r : q_r >> 1;
        sub_r <= sub_r >> 2;
      end else begin
        q_r   <= {q_r[ROOT_W-2:0], fits};
        sub_r <= sub_r >> 1;
      end
    end
  end

endmodule

>>> src/steric_clash_energy_accumulator_unit.sv
// Steric clash scorer: each request is one atom pair, and energies add into a
// saturating 48-bit total that is emitted on the pair marked last_pair and then
// cleared. A pair that falls outside the neighbor cutoff or has a nonpositive
// radius sum finishes first, one outside the summed radii next, then one in
// the hard core, and a pair on the ramp takes longest, since the shared
// root/divide unit must first work through 20 square-root steps and then
// 14 quotient steps, one bit per cycle. The squares and threshold products go
// one per cycle through a single 29x29 multiplier. The input is ready only
// between pairs; a finished total waits in the output register while the next
// pair is taken, and the unit stalls only when a second total is due before the
// first left. Configuration writes are taken in every cycle.
module steric_clash_energy_accumulator_unit (
  input logic                clk,
  input logic                rst_n,
  sceacc_in_if.sink          in_ch,
  sceacc_out_if.source       out_ch,
  sceacc_cfg_if.sink         cfg_ch
);
  import sceacc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_CUT,
    S_RR,
    S_TQ,
    S_T2,
    S_CORE,
    S_SQRT,
    S_RAMP,
    S_DIV,
    S_ACC
  } state_t;

  state_t               state_r, state_nxt;
  logic [OFFSET_W-1:0]  off_r, off_nxt;
  logic [MARGIN_W-1:0]  margin_r, margin_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]     out_total_r, out_total_nxt;
  logic                 out_sat_r, out_sat_nxt;
  logic [DIFF_W-1:0]    dx_r, dx_nxt;
  logic [DIFF_W-1:0]    dy_r, dy_nxt;
  logic [DIFF_W-1:0]    dz_r, dz_nxt;
  logic [CUT_W-1:0]     cut_r, cut_nxt;
  logic [RR_W-1:0]      rr_r, rr_nxt;
  logic                 last_r, last_nxt;
  logic [DSQ_W-1:0]     dsq_r, dsq_nxt;
  logic [ENERGY_W-1:0]  e_r, e_nxt;

  logic signed [MUL_IN_W-1:0] mul_a;
  logic signed [MUL_IN_W-1:0] mul_b;
  logic        [PROD_W-1:0]   prod_r;
  root_req_t                  root_req;
  root_sts_t                  root_sts;

  logic [URR_W-1:0]  urr;
  logic [BIGR_W-1:0] big_r;
  logic [BIGR_W:0]   root_s;
  logic [BIGR_W-1:0] s_clamp;
  logic [BIGR_W-1:0] ramp_diff;
  logic [PROD_W-1:0] dsq_wide;
  logic [SUM_W:0]    sum_add;
  logic              capped;
  logic [SUM_W-1:0]  acc_sum;
  logic              acc_ovf;

  sceacc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  sceacc_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .sts   (root_sts)
  );

  assign urr       = rr_r[URR_W-1:0];
  assign big_r     = {urr, 8'b0};
  assign root_s    = root_sts.result[BIGR_W:0];
  assign s_clamp   = (root_s > {1'b0, big_r}) ? big_r : root_s[BIGR_W-1:0];
  assign ramp_diff = big_r - s_clamp;
  assign dsq_wide  = {{(PROD_W - DSQ_W){1'b0}}, dsq_r};

  assign sum_add = {1'b0, sum_r} + {{(SUM_W + 1 - ENERGY_W){1'b0}}, e_r};
  assign capped  = sum_add >= {1'b0, SUM_MAX};
  assign acc_sum = capped ? SUM_MAX : sum_add[SUM_W-1:0];
  assign acc_ovf = ovf_r | capped;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.total_energy = out_total_r;
  assign out_ch.saturated    = out_sat_r;

  always_comb begin
    state_nxt     = state_r;
    off_nxt       = off_r;
    margin_nxt    = margin_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_sat_nxt   = out_sat_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    cut_nxt       = cut_r;
    rr_nxt        = rr_r;
    last_nxt      = last_r;
    dsq_nxt       = dsq_r;
    e_nxt         = e_r;
    mul_a         = '0;
    mul_b         = '0;
    root_req      = '0;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIUS_OFFSET: off_nxt = cfg_ch.data[OFFSET_W-1:0];
        REG_SEARCH_MARGIN: margin_nxt = cfg_ch.data[MARGIN_W-1:0];
        default: ;
      endcase
    end

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          dx_nxt   = {in_ch.b_x[COORD_W-1], in_ch.b_x} - {in_ch.a_x[COORD_W-1], in_ch.a_x};
          dy_nxt   = {in_ch.b_y[COORD_W-1], in_ch.b_y} - {in_ch.a_y[COORD_W-1], in_ch.a_y};
          dz_nxt   = {in_ch.b_z[COORD_W-1], in_ch.b_z} - {in_ch.a_z[COORD_W-1], in_ch.a_z};
          cut_nxt  = {1'b0, in_ch.a_radius} + {2'b0, margin_r};
          rr_nxt   = {2'b0, in_ch.a_radius} + {2'b0, in_ch.b_radius}
                     - {{(RR_W - OFFSET_W - 1){1'b0}}, off_r, 1'b0};
          last_nxt = in_ch.last_pair;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        mul_a     = {{(MUL_IN_W - DIFF_W){dx_r[DIFF_W-1]}}, dx_r};
        mul_b     = mul_a;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a     = {{(MUL_IN_W - DIFF_W){dy_r[DIFF_W-1]}}, dy_r};
        mul_b     = mul_a;
        dsq_nxt   = prod_r[DSQ_W-1:0];
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        mul_a     = {{(MUL_IN_W - DIFF_W){dz_r[DIFF_W-1]}}, dz_r};
        mul_b     = mul_a;
        dsq_nxt   = dsq_r + prod_r[DSQ_W-1:0];
        state_nxt = S_CUT;
      end
      S_CUT: begin
        mul_a     = {{(MUL_IN_W - CUT_W){1'b0}}, cut_r};
        mul_b     = mul_a;
        dsq_nxt   = dsq_r + prod_r[DSQ_W-1:0];
        state_nxt = S_RR;
      end
      S_RR: begin
        // product holds the cutoff squared
        mul_a = {{(MUL_IN_W - URR_W){1'b0}}, urr};
        mul_b = mul_a;
        if (dsq_wide > prod_r || rr_r[RR_W-1] || rr_r == '0) begin
          e_nxt     = '0;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_TQ;
        end
      end
      S_TQ: begin
        // product holds rr squared
        mul_a = {{(MUL_IN_W - 16){1'b0}}, CORE_Q16};
        mul_b = {{(MUL_IN_W - URR_W){1'b0}}, urr};
        if (dsq_wide > prod_r) begin
          e_nxt     = '0;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_T2;
        end
      end
      S_T2: begin
        mul_a     = {1'b0, prod_r[MUL_IN_W-2:0]};
        mul_b     = mul_a;
        state_nxt = S_CORE;
      end
      S_CORE: begin
        // dsq now fits 24 bits since it lies within rr squared
        if ({dsq_r[23:0], 32'b0} < prod_r) begin
          e_nxt     = CORE_ENERGY;
          state_nxt = S_ACC;
        end else begin
          root_req.start = 1'b1;
          root_req.op    = OP_SQRT;
          root_req.num   = {dsq_r[23:0], 16'b0};
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (root_sts.done) begin
          mul_a     = {{(MUL_IN_W - ENERGY_W){1'b0}}, RAMP_SCALE};
          mul_b     = {{(MUL_IN_W - BIGR_W){1'b0}}, ramp_diff};
          state_nxt = S_RAMP;
        end
      end
      S_RAMP: begin
        root_req.start = 1'b1;
        root_req.op    = OP_DIV;
        root_req.num   = prod_r[ROOT_W-1:0];
        root_req.den   = {{(ROOT_W - BIGR_W - DIV_STEPS + 1){1'b0}}, big_r,
                          {(DIV_STEPS - 1){1'b0}}};
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        if (root_sts.done) begin
          e_nxt     = root_sts.result[ENERGY_W-1:0];
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        // hold a last pair while an earlier total still waits at the output
        if (!(last_r && out_valid_r && !out_ch.ready)) begin
          if (last_r) begin
            out_valid_nxt = 1'b1;
            out_total_nxt = acc_sum;
            out_sat_nxt   = acc_ovf;
            sum_nxt       = '0;
            ovf_nxt       = 1'b0;
          end else begin
            sum_nxt = acc_sum;
            ovf_nxt = acc_ovf;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      off_r       <= RADIUS_OFFSET_RST;
      margin_r    <= SEARCH_MARGIN_RST;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      margin_r    <= margin_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      out_total_r <= out_total_nxt;
      out_sat_r   <= out_sat_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      dz_r        <= dz_nxt;
      cut_r       <= cut_nxt;
      rr_r        <= rr_nxt;
      last_r      <= last_nxt;
      dsq_r       <= dsq_nxt;
      e_r         <= e_nxt;
    end
  end

  a_root_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    root_sts.done |-> (state_r == S_SQRT || state_r == S_DIV))
    else $error("root unit finished outside a waiting state");

  a_ovf_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> sum_r == SUM_MAX)
    else $error("overflow flag set without a capped sum");

  a_energy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> e_r <= RAMP_SCALE)
    else $error("pair energy above ramp ceiling");

  a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ACC && last_r))
    else $error("total emitted without a last pair");

endmodule

>>> tb/steric_clash_energy_checker.sv
module steric_clash_energy_checker (
  input  logic  clk,
  input  logic  rst_n,
  sceacc_in_if  in_ch,
  sceacc_out_if out_ch,
  sceacc_cfg_if cfg_ch,
  output int    fail_count,
  output int    totals_pending,
  output int    pairs_seen,
  output int    totals_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sceacc_pkg::*;

  typedef struct {
    logic [SUM_W-1:0] total;
    logic             saturated;
  } score_t;

  score_t              due_totals[$];
  logic [OFFSET_W-1:0] offset_q;
  logic [MARGIN_W-1:0] margin_q;
  logic [SUM_W-1:0]    energy_acc;
  logic                acc_capped;
  int                  fails = 0;
  int                  pairs = 0;
  int                  totals = 0;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [ENERGY_W-1:0] clash_energy(
    input logic [COORD_W-1:0]  ax, ay, az,
    input logic [RADIUS_W-1:0] ra,
    input logic [COORD_W-1:0]  bx, by, bz,
    input logic [RADIUS_W-1:0] rb
  );
    longint      dx, dy, dz;
    logic [63:0] dsq, cut, urr, core_t, root, big_r;
    int          rr;
    dx  = longint'($signed(bx)) - longint'($signed(ax));
    dy  = longint'($signed(by)) - longint'($signed(ay));
    dz  = longint'($signed(bz)) - longint'($signed(az));
    dsq = dx * dx + dy * dy + dz * dz;
    cut = 64'(ra) + 64'(margin_q);
    if (dsq > cut * cut) return '0;
    rr = int'(ra) + int'(rb) - 2 * int'(offset_q);
    if (rr <= 0) return '0;
    urr = 64'(rr);
    if (dsq > urr * urr) return '0;
    // hard core: d < 0.8254*rr, compared in squares to stay exact
    core_t = 64'(CORE_Q16) * urr;
    if ((dsq << 32) < core_t * core_t) return CORE_ENERGY;
    root  = floor_sqrt(dsq << 16);
    big_r = urr << 8;
    if (root > big_r) root = big_r;
    return ENERGY_W'((64'(RAMP_SCALE) * (big_r - root)) / big_r);
  endfunction

  always @(posedge clk) begin : monitor
    logic [ENERGY_W-1:0] pair_e;
    score_t              want;
    if (!rst_n) begin
      offset_q   = RADIUS_OFFSET_RST;
      margin_q   = SEARCH_MARGIN_RST;
      energy_acc = '0;
      acc_capped = 1'b0;
      due_totals.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_RADIUS_OFFSET: offset_q = cfg_ch.data[OFFSET_W-1:0];
          REG_SEARCH_MARGIN: margin_q = cfg_ch.data[MARGIN_W-1:0];
          default: ;
        endcase
      end
      // check results first: a total can never leave on the edge its pair enters
      if (out_ch.valid && out_ch.ready) begin
        totals++;
        if (due_totals.size() == 0) begin
          $display("%0t: unexpected total: expected none, got total_energy %0d saturated %0d",
                   $time, out_ch.total_energy, out_ch.saturated);
          fails++;
        end else begin
          want = due_totals.pop_front();
          if (out_ch.total_energy !== want.total) begin
            $display("%0t: total_energy mismatch: expected %0d, got %0d",
                     $time, want.total, out_ch.total_energy);
            fails++;
          end
          if (out_ch.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %0d, got %0d",
                     $time, want.saturated, out_ch.saturated);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pairs++;
        pair_e = clash_energy(in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_radius,
                              in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_radius);
        if (SUM_W'(pair_e) > SUM_MAX - energy_acc) begin
          energy_acc = SUM_MAX;
          acc_capped = 1'b1;
        end else begin
          energy_acc = energy_acc + SUM_W'(pair_e);
          if (energy_acc == SUM_MAX) acc_capped = 1'b1;
        end
        if (in_ch.last_pair) begin
          due_totals.push_back('{energy_acc, acc_capped});
          energy_acc = '0;
          acc_capped = 1'b0;
        end
      end
    end
    fail_count     <= fails;
    totals_pending <= due_totals.size();
    pairs_seen     <= pairs;
    totals_seen    <= totals;
  end

endmodule

>>> tb/steric_clash_energy_accumulator_unit_test.sv
module steric_clash_energy_accumulator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sceacc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [COORD_W-1:0]   COORD_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0]   COORD_MIN = 24'h800000;
  localparam int DRAIN_CYCLES     = 64;
  localparam int PHASE_PAIRS      = 240;
  localparam int LONG_HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  sceacc_in_if  in_bus();
  sceacc_out_if out_bus();
  sceacc_cfg_if cfg_bus();

  int fail_count;
  int totals_pending;
  int pairs_seen;
  int totals_seen;
  int settings_used;
  int send_burst = 0;
  int recv_burst = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  logic [OFFSET_W-1:0] cur_offset;
  logic [MARGIN_W-1:0] cur_margin;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  steric_clash_energy_accumulator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  steric_clash_energy_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_bus),
    .out_ch         (out_bus),
    .cfg_ch         (cfg_bus),
    .fail_count     (fail_count),
    .totals_pending (totals_pending),
    .pairs_seen     (pairs_seen),
    .totals_seen    (totals_seen)
  );

  // mostly a random idle gap, with occasional runs of back-to-back requests
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic send_pair(
    input logic [COORD_W-1:0]  ax, ay, az,
    input logic [RADIUS_W-1:0] ra,
    input logic [COORD_W-1:0]  bx, by, bz,
    input logic [RADIUS_W-1:0] rb,
    input bit                  last
  );
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.a_x       <= ax;
    in_bus.a_y       <= ay;
    in_bus.a_z       <= az;
    in_bus.a_radius  <= ra;
    in_bus.b_x       <= bx;
    in_bus.b_y       <= by;
    in_bus.b_z       <= bz;
    in_bus.b_radius  <= rb;
    in_bus.last_pair <= last;
    in_bus.valid     <= 1'b1;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  task automatic send_random_pair(input bit last);
    logic [COORD_W-1:0]  ax, ay, az;
    logic [RADIUS_W-1:0] ra, rb;
    int                  rr, mag, axis, kind;
    int                  delta [3];
    ax = COORD_W'($urandom);
    ay = COORD_W'($urandom);
    az = COORD_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      ra = RADIUS_W'($urandom_range(0, 2047));
      rb = RADIUS_W'($urandom_range(0, 2047));
    end else begin
      ra = RADIUS_W'($urandom_range(200, 700));
      rb = RADIUS_W'($urandom_range(200, 700));
    end
    rr = int'(ra) + int'(rb) - 2 * int'(cur_offset);
    if (rr < 1) rr = 1;
    // aim the distance at the ramp, the core, the shell past rr or the cutoff edge, or put b anywhere
    kind = $urandom_range(0, 9);
    if (kind <= 4)
      mag = rr * $urandom_range(800, 1000) / 1000;
    else if (kind <= 6)
      mag = $urandom_range(0, rr * 83 / 100);
    else if (kind == 7)
      mag = rr + $urandom_range(0, int'(ra) + int'(cur_margin) + 1);
    else
      mag = int'(ra) + int'(cur_margin) + $urandom_range(0, 4) - 2;
    if (mag < 0) mag = 0;
    axis = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      delta[k] = (k == axis) ? mag : $urandom_range(0, mag / 8);
      if ($urandom_range(0, 1)) delta[k] = -delta[k];
    end
    if (kind == 9)
      send_pair(ax, ay, az, ra, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), rb, last);
    else
      send_pair(ax, ay, az, ra, ax + COORD_W'(delta[0]), ay + COORD_W'(delta[1]),
                az + COORD_W'(delta[2]), rb, last);
  endtask

  task automatic random_phase(input int count, input int last_odds);
    for (int i = 0; i < count; i++)
      send_random_pair($urandom_range(1, last_odds) == 1);
  endtask

  // drop valid, wait for every total, then let a pair with no total finish
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (totals_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(
    input logic [OFFSET_W-1:0] offset_val,
    input logic [MARGIN_W-1:0] margin_val,
    input bit                  poke_spare
  );
    // junk in the upper data bits must be dropped by the block
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_RADIUS_OFFSET;
    cfg_bus.data  <= {8'($urandom), offset_val};
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.index <= REG_SEARCH_MARGIN;
    cfg_bus.data  <= {6'($urandom), margin_val};
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    if (poke_spare) begin
      cfg_bus.index <= REG_SPARE;
      cfg_bus.data  <= 16'($urandom);
      do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    end
    cfg_bus.valid <= 1'b0;
    cur_offset = offset_val;
    cur_margin = margin_val;
    settings_used++;
  endtask

  initial begin : result_sink
    int gap;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  initial begin : stimulus
    in_bus.valid     <= 1'b0;
    in_bus.a_x       <= '0;
    in_bus.a_y       <= '0;
    in_bus.a_z       <= '0;
    in_bus.a_radius  <= '0;
    in_bus.b_x       <= '0;
    in_bus.b_y       <= '0;
    in_bus.b_z       <= '0;
    in_bus.b_radius  <= '0;
    in_bus.last_pair <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_RADIUS_OFFSET;
    cfg_bus.data     <= '0;
    rst_n            <= 1'b0;
    cur_offset    = RADIUS_OFFSET_RST;
    cur_margin    = SEARCH_MARGIN_RST;
    settings_used = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: offset 64, margin 435, so rr = 672 for two 400 radii
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1000, -24'sd2000, 24'sd3000, 11'd400, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1605, -24'sd2000, 24'sd3000, 11'd400, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1000, -24'sd1446, 24'sd3000, 11'd400, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1000, -24'sd1445, 24'sd3000, 11'd400, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1000, -24'sd2000, 24'sd3672, 11'd400, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1000, -24'sd2000, 24'sd3673, 11'd400, 1'b1);
    send_pair(COORD_MIN, COORD_MIN, COORD_MIN, 11'd2047,
              COORD_MAX, COORD_MAX, COORD_MAX, 11'd2047, 1'b0);
    send_pair(COORD_MAX, COORD_MAX, COORD_MAX, 11'd0,
              COORD_MIN, COORD_MIN, COORD_MIN, 11'd0, 1'b1);
    // radius sum negative, then exactly zero
    send_pair(24'sd50, 24'sd50, 24'sd50, 11'd0, 24'sd50, 24'sd50, 24'sd50, 11'd0, 1'b0);
    send_pair(24'sd50, 24'sd50, 24'sd50, 11'd64, 24'sd50, 24'sd50, 24'sd50, 11'd64, 1'b0);
    send_pair(-24'sd7, 24'sd9, -24'sd11, 11'd2047,
              -24'sd7, 24'sd9, -24'sd11, 11'd2047, 1'b1);
    // neighbor cutoff edge: 100 + 435 = 535
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd100,
              24'sd1535, -24'sd2000, 24'sd3000, 11'd2047, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd100,
              24'sd1536, -24'sd2000, 24'sd3000, 11'd2047, 1'b1);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd395, -24'sd2000, 24'sd3000, 11'd400, 1'b0);
    send_pair(24'sd1000, -24'sd2000, 24'sd3000, 11'd400,
              24'sd1350, -24'sd1650, 24'sd3350, 11'd400, 1'b1);
    send_pair(COORD_MAX - 24'd100, COORD_MAX, COORD_MAX, 11'd300,
              COORD_MAX, COORD_MAX, COORD_MAX, 11'd300, 1'b0);
    send_pair(COORD_MIN + 24'd200, COORD_MIN, COORD_MIN, 11'd300,
              COORD_MIN, COORD_MIN, COORD_MIN, 11'd300, 1'b0);
    send_pair(COORD_MIN + 24'd425, COORD_MIN, COORD_MIN, 11'd300,
              COORD_MIN, COORD_MIN, COORD_MIN, 11'd300, 1'b1);
    send_pair(24'sd0, 24'sd0, 24'sd0, 11'd200, 24'sd0, 24'sd5000, 24'sd0, 11'd200, 1'b1);
    random_phase(PHASE_PAIRS, 6);
    drain();

    for (int phase = 1; phase < 8; phase++) begin
      case (phase)
        1: write_regs(8'd0, 10'd1023, 1'b1);
        2: write_regs(8'd255, 10'd0, 1'b0);
        3: write_regs(8'd0, 10'd0, 1'b0);
        4: write_regs(8'd64, 10'd512, 1'b0);
        5: write_regs(8'd255, 10'd1023, 1'b0);
        default: write_regs(OFFSET_W'($urandom_range(0, 255)),
                            MARGIN_W'($urandom_range(0, 1023)), phase == 6);
      endcase
      if (phase == 4) begin
        // hold the result side while every pair asks for a total
        long_hold_req = 1'b1;
        random_phase(60, 1);
        random_phase(PHASE_PAIRS - 60, 6);
      end else begin
        random_phase(PHASE_PAIRS, 6);
      end
      drain();
    end

    $display("Scored %0d atom pairs into %0d checked totals over %0d register settings,",
             pairs_seen, totals_seen, settings_used);
    $display("with 0-6 cycle gaps on both sides and one %0d-cycle result hold-off.",
             LONG_HOLD_CYCLES);
    if (fail_count == 0 && totals_pending == 0)
      $display("** steric_clash_energy_accumulator_unit: PASSED **");
    else
      $display("** steric_clash_energy_accumulator_unit: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d totals still due", totals_pending);
    $display("** steric_clash_energy_accumulator_unit: FAILED **");
    $finish;
  end

endmodule

>>> files.f
src/sceacc_pkg.sv
src/sceacc_if.sv
src/sceacc_mul.sv
src/sceacc_root.sv
src/steric_clash_energy_accumulator_unit.sv
tb/steric_clash_energy_checker.sv
tb/steric_clash_energy_accumulator_unit_test.sv
